>>> rtl/core/emsq_pkg.sv
// ----------------------------------------------------------------------------
// Eased two-servo motion sequencer package
// Shared widths, codes, the keyframe record and the cosine ease table.
// ----------------------------------------------------------------------------
package emsq_pkg;

	localparam int MAX_KEYFRAMES   = 8;
	localparam int TICK_MS         = 20;
	localparam int EASE_TABLE_BITS = 8;

	localparam int EASE_N     = 1 << EASE_TABLE_BITS;
	localparam int EASE_SHIFT = 16 - EASE_TABLE_BITS;
	localparam int EASE_IDX_W = EASE_TABLE_BITS + 1;
	localparam int KF_IDX_W   = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
	localparam int KF_CNT_W   = 4;
	localparam int FP_W       = $clog2(MAX_KEYFRAMES + 1) + 1;

	localparam logic [16:0] TIME_SAT  = 17'h1FFFF;
	localparam logic [16:0] EASE_ONE  = 17'h10000;
	localparam logic [9:0]  CTR_RESET = 10'd512;
	localparam logic [9:0]  MIN_RESET = 10'd0;
	localparam logic [9:0]  MAX_RESET = 10'd1023;

	// Reciprocal of 300 in Q26, used for the degree to step conversion.
	localparam int unsigned DEG_RECIP = (1 << 26) / 300;

	// Operation codes.
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_MOVE  = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_KFW   = 3'd3;
	localparam logic [2:0] OP_PLAY  = 3'd4;

	// Status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_BUSY    = 2'd2;

	// Result kinds.
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_POS    = 1'b1;

	// Configuration register indexes.
	localparam logic [2:0] CFG_PAN_MIN  = 3'd0;
	localparam logic [2:0] CFG_PAN_CTR  = 3'd1;
	localparam logic [2:0] CFG_PAN_MAX  = 3'd2;
	localparam logic [2:0] CFG_TILT_MIN = 3'd3;
	localparam logic [2:0] CFG_TILT_CTR = 3'd4;
	localparam logic [2:0] CFG_TILT_MAX = 3'd5;

	// One keyframe, with the degree offset already converted to steps.
	typedef struct packed {
		logic               servo;
		logic signed [10:0] off;
		logic [15:0]        dur;
		logic [15:0]        hold;
	} kf_t;

	typedef logic [16:0] ease_tab_t [0:EASE_N];

	// Lower half of the ease curve from an eight-term cosine series.
	function automatic logic [16:0] ease_low(int unsigned i);
		logic [63:0] theta;
		logic [63:0] th2;
		logic [63:0] term;
		logic [63:0] sum;
		theta = (64'd3373259426 * 64'(i)) >> EASE_TABLE_BITS;
		th2   = (theta * theta) >> 30;
		term  = th2 >> 1;
		sum   = term;
		for (int k = 2; k <= 8; k++) begin
			term = (term * th2) >> 30;
			term = term / 64'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) sum = sum + term;
			else sum = sum - term;
		end
		return 17'((sum + 64'd16384) >> 15);
	endfunction

	function automatic ease_tab_t build_ease();
		ease_tab_t t;
		for (int i = 0; i <= EASE_N; i++) begin
			if (i >= EASE_N) t[i] = EASE_ONE;
			else if (2 * i > EASE_N) t[i] = EASE_ONE - ease_low(unsigned'(EASE_N - i));
			else t[i] = ease_low(unsigned'(i));
		end
		return t;
	endfunction

	localparam ease_tab_t EASE_TAB = build_ease();

	// Timer step with saturation at 17 bits.
	function automatic logic [16:0] sat_tick(logic [16:0] x);
		logic [17:0] s;
		s = {1'b0, x} + 18'(TICK_MS);
		return (s > {1'b0, TIME_SAT}) ? TIME_SAT : s[16:0];
	endfunction

	// Centre plus offset, clamped to the minimum first and then the maximum.
	function automatic logic [9:0] clamp_goal(logic [9:0] ctr, logic signed [10:0] off,
			logic [9:0] lo, logic [9:0] hi);
		logic signed [12:0] p;
		p = $signed({3'b000, ctr}) + 13'(off);
		if (p < $signed({3'b000, lo})) p = $signed({3'b000, lo});
		if (p > $signed({3'b000, hi})) p = $signed({3'b000, hi});
		return p[9:0];
	endfunction

endpackage

>>> rtl/core/emsq_if.sv
// ----------------------------------------------------------------------------
// Eased two-servo motion sequencer channels
// Command and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface emsq_cmd_if import emsq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [2:0]        op;
	logic [1:0]        servo_sel;
	logic [9:0]        target_steps;
	logic [15:0]       move_ms;
	logic signed [8:0] offset_degrees;
	logic [15:0]       hold_time_ms;
	logic [2:0]        frame_slot;
	logic [KF_CNT_W-1:0] frames_in_use;

	modport source (output valid, op, servo_sel, target_steps, move_ms, offset_degrees,
		hold_time_ms, frame_slot, frames_in_use, input ready);
	modport sink (input valid, op, servo_sel, target_steps, move_ms, offset_degrees,
		hold_time_ms, frame_slot, frames_in_use, output ready);
endinterface

interface emsq_rsp_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic       servo_out;
	logic [9:0] position;
	logic [1:0] status;
	logic       pan_moving;
	logic       tilt_moving;
	logic       sequence_active;
	logic       last;

	modport source (output valid, kind, servo_out, position, status, pan_moving,
		tilt_moving, sequence_active, last, input ready);
	modport sink (input valid, kind, servo_out, position, status, pan_moving,
		tilt_moving, sequence_active, last, output ready);
endinterface

>>> rtl/core/emsq_div.sv
// ----------------------------------------------------------------------------
// Eased two-servo motion sequencer fraction divider
// Restoring divider giving floor(a * 2^16 / b) for a < b, one bit a cycle.
// ----------------------------------------------------------------------------
module emsq_div import emsq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [15:0] quot
);

	logic [15:0] rem_q;
	logic [15:0] div_q;
	logic [15:0] quot_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] rem_x2;

	assign rem_x2 = {rem_q, 1'b0};

	// One quotient bit per cycle; the remainder stays below the divisor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			div_q  <= '0;
			quot_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rem_q  <= dividend;
			div_q  <= divisor;
			cnt_q  <= 5'd16;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (rem_x2 >= {1'b0, div_q}) begin
				rem_q  <= 16'(rem_x2 - {1'b0, div_q});
				quot_q <= {quot_q[14:0], 1'b1};
			end else begin
				rem_q  <= rem_x2[15:0];
				quot_q <= {quot_q[14:0], 1'b0};
			end
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> rtl/core/eased_two_servo_motion_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Eased two-servo motion sequencer
// Pan and tilt servo control with cosine-eased moves and a keyframe player.
// ----------------------------------------------------------------------------
// Commands arrive on cmd (tick, move, stop, keyframe write, play) and are
// taken one at a time: cmd.ready is high only while the block is idle.
// Each command gives one or two results on rsp; the last one carries last.
// A tick gives a position write for each servo that moves, or one status.
// A move, stop or unknown command shows its status in the cycle after the
// transfer; an accepted play first passes through S_PLAY, an accepted
// keyframe write through S_CV1, S_CV2 and S_CV3. For each servo with move
// time left, a tick runs the serial divider to form the 16-bit time fraction,
// then the ease table lookup, the interpolation multiply and limit check.
// Results wait in a two-entry buffer until rsp.ready is high; while the
// receiver stalls the block takes no new command. The moving and sequence
// flags on rsp show the state after the whole command.
// The configuration port writes the six limit and centre registers at any
// idle cycle. Reset restores the default limits, centres both servos and
// stops any move or sequence; keyframes hold no defined value until written.
module eased_two_servo_motion_sequencer_unit import emsq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	emsq_cmd_if.sink    cmd,
	emsq_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [9:0]  cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_CV1, S_CV2, S_CV3, S_PLAY, S_SEQ, S_NF, S_UPD,
		S_DIV, S_EASE1, S_EASE2, S_MUL, S_POS, S_FIN, S_OUT
	} state_t;

	state_t state_q;

	logic [9:0]  cfg_min_q [2];
	logic [9:0]  cfg_ctr_q [2];
	logic [9:0]  cfg_max_q [2];

	logic [9:0]  start_q   [2];
	logic [9:0]  goal_q    [2];
	logic [9:0]  cur_q     [2];
	logic [15:0] total_q   [2];
	logic [16:0] elapsed_q [2];
	logic [1:0]  busy_q;
	logic [1:0]  stop_q;

	kf_t         kf_q [MAX_KEYFRAMES];
	logic [FP_W-1:0]     frame_pos_q;
	logic [KF_CNT_W-1:0] frame_total_q;
	logic [16:0] hold_el_q;
	logic        run_q;
	logic        holding_q;

	logic        sv_q;
	logic        kf_sel_q;
	logic [2:0]  kf_slot_q;
	logic [15:0] kf_dur_q;
	logic [15:0] kf_hold_q;
	logic signed [8:0] kf_deg_q;
	logic        cv_neg_q;
	logic [17:0] cv_abs_q;
	logic [9:0]  cv_q0_q;

	logic [16:0] e0_q;
	logic [16:0] d_q;
	logic [EASE_SHIFT-1:0] f_q;
	logic [16:0] ease_q;
	logic [9:0]  mag_q;
	logic        up_q;

	logic        res_kind_q [2];
	logic        res_sv_q   [2];
	logic [9:0]  res_pos_q  [2];
	logic [1:0]  res_st_q   [2];
	logic [1:0]  res_cnt_q;
	logic        res_rd_q;

	// Combinational views used by the sequencer.
	kf_t         kf_rd;
	logic [9:0]  kf_goal;
	logic        kf_goal_ok;
	logic [16:0] hold_sum;
	logic [16:0] el_sum;
	logic        div_start;
	logic        div_done;
	logic [15:0] div_quot;
	logic        mv_ok;
	logic signed [19:0] cv_n;
	logic [35:0] cv_prod;
	logic [18:0] cv_rem;
	logic [9:0]  cv_q;
	logic [EASE_IDX_W-1:0] ease_j;
	logic [24:0] ease_prod;
	logic [9:0]  delta;
	logic [26:0] mag_prod;
	logic [9:0]  new_pos;
	logic [FP_W-1:0] fp_next;

	assign kf_rd      = kf_q[frame_pos_q[KF_IDX_W-1:0]];
	assign kf_goal    = clamp_goal(cfg_ctr_q[kf_rd.servo], kf_rd.off,
		cfg_min_q[kf_rd.servo], cfg_max_q[kf_rd.servo]);
	assign kf_goal_ok = (kf_goal >= cfg_min_q[kf_rd.servo]) &&
		(kf_goal <= cfg_max_q[kf_rd.servo]);
	assign hold_sum   = sat_tick(hold_el_q);
	assign el_sum     = sat_tick(elapsed_q[sv_q]);
	assign fp_next    = frame_pos_q + FP_W'(1);

	assign div_start = (state_q == S_UPD) && busy_q[sv_q] && !stop_q[sv_q] &&
		(el_sum < {1'b0, total_q[sv_q]});

	assign mv_ok = (cmd.move_ms != 16'd0) && (cmd.servo_sel <= 2'd1) &&
		(cmd.target_steps >= cfg_min_q[cmd.servo_sel[0]]) &&
		(cmd.target_steps <= cfg_max_q[cmd.servo_sel[0]]);

	// Degree conversion: trunc((deg * 1023 + 150) / 300) by reciprocal.
	assign cv_n    = 20'(kf_deg_q) * 20'sd1023 + 20'sd150;
	assign cv_prod = 36'(cv_abs_q) * 36'(DEG_RECIP);
	assign cv_rem  = 19'(cv_abs_q) - 19'(cv_q0_q) * 19'd300;
	assign cv_q    = (cv_rem >= 19'd300) ? cv_q0_q + 10'd1 : cv_q0_q;

	// Ease interpolation and offset magnitude.
	assign ease_j    = {1'b0, div_quot[15:EASE_SHIFT]};
	assign ease_prod = 25'(d_q) * 25'(f_q);
	assign delta     = (goal_q[sv_q] >= start_q[sv_q]) ? goal_q[sv_q] - start_q[sv_q]
		: start_q[sv_q] - goal_q[sv_q];
	assign mag_prod  = 27'(delta) * 27'(ease_q);
	assign new_pos   = up_q ? start_q[sv_q] + mag_q : start_q[sv_q] - mag_q;

	emsq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (el_sum[15:0]),
		.divisor  (total_q[sv_q]),
		.done     (div_done),
		.quot     (div_quot)
	);

	// Keyframe store, written once the offset conversion is finished.
	always_ff @(posedge clk) begin
		if (state_q == S_CV3) begin
			kf_q[kf_slot_q[KF_IDX_W-1:0]] <= '{servo: kf_sel_q,
				off: cv_neg_q ? -$signed({1'b0, cv_q}) : $signed({1'b0, cv_q}),
				dur: kf_dur_q, hold: kf_hold_q};
		end
	end

	// Sequencer, servo state, configuration and result buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int s = 0; s < 2; s++) begin
				cfg_min_q[s] <= MIN_RESET;
				cfg_ctr_q[s] <= CTR_RESET;
				cfg_max_q[s] <= MAX_RESET;
				start_q[s]   <= CTR_RESET;
				goal_q[s]    <= CTR_RESET;
				cur_q[s]     <= CTR_RESET;
				total_q[s]   <= '0;
				elapsed_q[s] <= '0;
				res_kind_q[s] <= KIND_STATUS;
				res_sv_q[s]   <= 1'b0;
				res_pos_q[s]  <= '0;
				res_st_q[s]   <= ST_OK;
			end
			busy_q        <= '0;
			stop_q        <= '0;
			frame_pos_q   <= '0;
			frame_total_q <= '0;
			hold_el_q     <= '0;
			run_q         <= 1'b0;
			holding_q     <= 1'b0;
			sv_q          <= 1'b0;
			kf_sel_q      <= 1'b0;
			kf_slot_q     <= '0;
			kf_dur_q      <= '0;
			kf_hold_q     <= '0;
			kf_deg_q      <= '0;
			cv_neg_q      <= 1'b0;
			cv_abs_q      <= '0;
			cv_q0_q       <= '0;
			e0_q          <= '0;
			d_q           <= '0;
			f_q           <= '0;
			ease_q        <= '0;
			mag_q         <= '0;
			up_q          <= 1'b0;
			res_cnt_q     <= '0;
			res_rd_q      <= 1'b0;
		end else begin
			// Configuration writes; indexes past the list are ignored.
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_PAN_MIN:  cfg_min_q[0] <= cfg_data;
					CFG_PAN_CTR:  cfg_ctr_q[0] <= cfg_data;
					CFG_PAN_MAX:  cfg_max_q[0] <= cfg_data;
					CFG_TILT_MIN: cfg_min_q[1] <= cfg_data;
					CFG_TILT_CTR: cfg_ctr_q[1] <= cfg_data;
					CFG_TILT_MAX: cfg_max_q[1] <= cfg_data;
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						res_rd_q      <= 1'b0;
						res_cnt_q     <= 2'd1;
						res_kind_q[0] <= KIND_STATUS;
						res_sv_q[0]   <= 1'b0;
						res_pos_q[0]  <= '0;
						res_st_q[0]   <= ST_OK;
						state_q       <= S_OUT;
						kf_sel_q      <= cmd.servo_sel[0];
						kf_slot_q     <= cmd.frame_slot;
						kf_dur_q      <= cmd.move_ms;
						kf_hold_q     <= cmd.hold_time_ms;
						kf_deg_q      <= cmd.offset_degrees;
						unique case (cmd.op)
							OP_TICK: begin
								res_cnt_q <= 2'd0;
								sv_q      <= 1'b0;
								state_q   <= S_SEQ;
							end
							OP_MOVE: begin
								if (!mv_ok) begin
									res_st_q[0] <= ST_INVALID;
								end else begin
									run_q <= 1'b0;
									start_q[cmd.servo_sel[0]]   <= cur_q[cmd.servo_sel[0]];
									goal_q[cmd.servo_sel[0]]    <= cmd.target_steps;
									total_q[cmd.servo_sel[0]]   <= cmd.move_ms;
									elapsed_q[cmd.servo_sel[0]] <= '0;
									busy_q[cmd.servo_sel[0]]    <= 1'b1;
									stop_q[cmd.servo_sel[0]]    <= 1'b0;
								end
							end
							OP_STOP: begin
								if (cmd.servo_sel != 2'd1) stop_q[0] <= 1'b1;
								if (cmd.servo_sel != 2'd0) stop_q[1] <= 1'b1;
								run_q <= 1'b0;
							end
							OP_KFW: begin
								if (cmd.servo_sel > 2'd1 ||
										int'(cmd.frame_slot) >= MAX_KEYFRAMES) begin
									res_st_q[0] <= ST_INVALID;
								end else if (run_q) begin
									res_st_q[0] <= ST_BUSY;
								end else begin
									state_q <= S_CV1;
								end
							end
							OP_PLAY: begin
								if (cmd.frames_in_use == '0 ||
										int'(cmd.frames_in_use) > MAX_KEYFRAMES) begin
									res_st_q[0] <= ST_INVALID;
								end else if (run_q) begin
									res_st_q[0] <= ST_BUSY;
								end else begin
									frame_pos_q   <= '0;
									frame_total_q <= cmd.frames_in_use;
									state_q       <= S_PLAY;
								end
							end
							default: begin
								res_st_q[0] <= ST_INVALID;
							end
						endcase
					end
				end

				// Offset conversion in three steps: magnitude, estimate, correction.
				S_CV1: begin
					cv_neg_q <= cv_n[19];
					cv_abs_q <= cv_n[19] ? 18'(-cv_n) : cv_n[17:0];
					state_q  <= S_CV2;
				end
				S_CV2: begin
					cv_q0_q <= cv_prod[35:26];
					state_q <= S_CV3;
				end
				S_CV3: begin
					state_q <= S_OUT;
				end

				// Start of a sequence from frame zero.
				S_PLAY: begin
					if (kf_rd.dur == 16'd0 || !kf_goal_ok) begin
						res_st_q[0] <= ST_INVALID;
					end else begin
						start_q[kf_rd.servo]   <= cur_q[kf_rd.servo];
						goal_q[kf_rd.servo]    <= kf_goal;
						total_q[kf_rd.servo]   <= kf_rd.dur;
						elapsed_q[kf_rd.servo] <= '0;
						busy_q[kf_rd.servo]    <= 1'b1;
						stop_q[kf_rd.servo]    <= 1'b0;
						hold_el_q <= '0;
						run_q     <= 1'b1;
						holding_q <= 1'b0;
					end
					state_q <= S_OUT;
				end

				// Keyframe player: wait for the move, hold, then the next frame.
				S_SEQ: begin
					state_q <= S_UPD;
					if (run_q) begin
						if (holding_q) begin
							hold_el_q <= hold_sum;
							if (hold_sum >= {1'b0, kf_rd.hold}) begin
								frame_pos_q <= fp_next;
								if (fp_next >= FP_W'(frame_total_q)) run_q <= 1'b0;
								else state_q <= S_NF;
							end
						end else if (!busy_q[kf_rd.servo]) begin
							if (kf_rd.hold != 16'd0) begin
								holding_q <= 1'b1;
								hold_el_q <= '0;
							end else begin
								frame_pos_q <= fp_next;
								if (fp_next >= FP_W'(frame_total_q)) run_q <= 1'b0;
								else state_q <= S_NF;
							end
						end
					end
				end
				S_NF: begin
					start_q[kf_rd.servo]   <= cur_q[kf_rd.servo];
					goal_q[kf_rd.servo]    <= kf_goal;
					total_q[kf_rd.servo]   <= kf_rd.dur;
					elapsed_q[kf_rd.servo] <= '0;
					busy_q[kf_rd.servo]    <= 1'b1;
					stop_q[kf_rd.servo]    <= 1'b0;
					holding_q <= 1'b0;
					hold_el_q <= '0;
					state_q   <= S_UPD;
				end

				// Servo update: pending stop, timer step, end of move or divide.
				S_UPD: begin
					if (!busy_q[sv_q]) begin
						sv_q    <= 1'b1;
						state_q <= sv_q ? S_FIN : S_UPD;
					end else if (stop_q[sv_q]) begin
						stop_q[sv_q] <= 1'b0;
						busy_q[sv_q] <= 1'b0;
						sv_q    <= 1'b1;
						state_q <= sv_q ? S_FIN : S_UPD;
					end else begin
						elapsed_q[sv_q] <= el_sum;
						if (el_sum >= {1'b0, total_q[sv_q]}) begin
							ease_q       <= EASE_ONE;
							busy_q[sv_q] <= 1'b0;
							state_q      <= S_MUL;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) state_q <= S_EASE1;
				end
				S_EASE1: begin
					e0_q    <= EASE_TAB[ease_j];
					d_q     <= EASE_TAB[ease_j + EASE_IDX_W'(1)] - EASE_TAB[ease_j];
					f_q     <= div_quot[EASE_SHIFT-1:0];
					state_q <= S_EASE2;
				end
				S_EASE2: begin
					ease_q  <= e0_q + 17'(ease_prod >> EASE_SHIFT);
					state_q <= S_MUL;
				end
				S_MUL: begin
					up_q    <= goal_q[sv_q] >= start_q[sv_q];
					mag_q   <= mag_prod[25:16];
					state_q <= S_POS;
				end
				S_POS: begin
					if (new_pos >= cfg_min_q[sv_q] && new_pos <= cfg_max_q[sv_q]) begin
						cur_q[sv_q] <= new_pos;
						res_kind_q[res_cnt_q[0]] <= KIND_POS;
						res_sv_q[res_cnt_q[0]]   <= sv_q;
						res_pos_q[res_cnt_q[0]]  <= new_pos;
						res_st_q[res_cnt_q[0]]   <= ST_OK;
						res_cnt_q <= res_cnt_q + 2'd1;
					end else begin
						busy_q[sv_q] <= 1'b0;
					end
					sv_q    <= 1'b1;
					state_q <= sv_q ? S_FIN : S_UPD;
				end
				S_FIN: begin
					if (res_cnt_q == 2'd0) begin
						res_kind_q[0] <= KIND_STATUS;
						res_sv_q[0]   <= 1'b0;
						res_pos_q[0]  <= '0;
						res_st_q[0]   <= ST_OK;
						res_cnt_q     <= 2'd1;
					end
					state_q <= S_OUT;
				end

				// Result transfers, in order, until the last one is taken.
				S_OUT: begin
					if (rsp.ready) begin
						if ({1'b0, res_rd_q} == res_cnt_q - 2'd1) state_q <= S_IDLE;
						else res_rd_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd.ready = (state_q == S_IDLE);

	assign rsp.valid           = (state_q == S_OUT);
	assign rsp.kind            = res_kind_q[res_rd_q];
	assign rsp.servo_out       = res_sv_q[res_rd_q];
	assign rsp.position        = res_pos_q[res_rd_q];
	assign rsp.status          = res_st_q[res_rd_q];
	assign rsp.pan_moving      = busy_q[0];
	assign rsp.tilt_moving     = busy_q[1];
	assign rsp.sequence_active = run_q;
	assign rsp.last            = ({1'b0, res_rd_q} == res_cnt_q - 2'd1);

endmodule
